/* design/lcae_pkg.sv */
// Shared types, codes and constants of the Game of Life engine.
package lcae_pkg;

    // Field and register widths.
    localparam int OP_W      = 2;
    localparam int COORD_W   = 7;
    localparam int POP_W     = 15;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 1;

    // Default grid store size.
    localparam int DEF_MAX_ROWS = 128;
    localparam int DEF_MAX_COLS = 128;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
    localparam logic [OP_W-1:0] OP_TOGGLE = 2'd1;
    localparam logic [OP_W-1:0] OP_STEP   = 2'd2;
    localparam logic [OP_W-1:0] OP_READ   = 2'd3;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'd1;
    localparam logic [CFG_W-1:0]     GRID_ROWS_RST = 8'd72;
    localparam logic [CFG_W-1:0]     GRID_COLS_RST = 8'd128;

    // The population count saturates here.
    localparam logic [POP_W-1:0] POP_MAX = 15'h7FFF;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic cell_update;
        logic step_init;
        logic load0;
        logic row_start;
        logic col_step;
        logic row_write;
        logic clear_row;
        logic load_out;
    } lcae_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_is_step;
        logic in_err;
        logic row_skip;
        logic col_last;
        logic row_last;
    } lcae_status_t;

endpackage

/* design/lcae_ctrl.sv */
// Controller state machine: sequences cell accesses, generation steps and the reset clear.
module lcae_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    output logic                     out_valid,
    input  logic                     out_stall,
    input  lcae_pkg::lcae_status_t   status,
    output lcae_pkg::lcae_cmd_t      cmd
);
    import lcae_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CELL,
        S_INIT,
        S_LOAD0,
        S_ROWSTART,
        S_COL,
        S_ROWWRITE,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // The output slot can take a result when empty or emptied this cycle.
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_row = 1'b1;
                if (status.row_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.in_is_step)
                    begin
                        state_next = S_INIT;
                    end
                    else if (status.in_err)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_CELL;
                    end
                end
            end
            S_CELL:
            begin
                cmd.cell_update = 1'b1;
                state_next      = S_DONE;
            end
            S_INIT:
            begin
                cmd.step_init = 1'b1;
                state_next    = S_LOAD0;
            end
            S_LOAD0:
            begin
                cmd.load0  = 1'b1;
                state_next = S_ROWSTART;
            end
            S_ROWSTART:
            begin
                cmd.row_start = 1'b1;
                state_next    = status.row_skip ? S_ROWWRITE : S_COL;
            end
            S_COL:
            begin
                cmd.col_step = 1'b1;
                if (status.col_last)
                begin
                    state_next = S_ROWWRITE;
                end
            end
            S_ROWWRITE:
            begin
                cmd.row_write = 1'b1;
                state_next    = status.row_last ? S_DONE : S_ROWSTART;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid follows loads and completed output transactions.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* design/lcae_datapath.sv */
// Datapath: cell store, line buffers, neighbor count, population and result registers.
module lcae_datapath #(
    parameter int MAX_ROWS = lcae_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = lcae_pkg::DEF_MAX_COLS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [lcae_pkg::OP_W-1:0]         op,
    input  logic [lcae_pkg::COORD_W-1:0]      cell_row,
    input  logic [lcae_pkg::COORD_W-1:0]      cell_col,
    input  logic                              cell_value,
    input  logic                              cfg_we,
    input  logic [lcae_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lcae_pkg::CFG_W-1:0]        cfg_data,
    input  lcae_pkg::lcae_cmd_t               cmd,
    output lcae_pkg::lcae_status_t            status,
    output logic                              alive,
    output logic                              coord_error,
    output logic [lcae_pkg::POP_W-1:0]        population
);
    import lcae_pkg::*;

    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);
    localparam int RN = $clog2(MAX_ROWS + 1);
    localparam int CN = $clog2(MAX_COLS + 1);

    // Configuration registers.
    logic [CFG_W-1:0] grid_rows_reg;
    logic [CFG_W-1:0] grid_cols_reg;

    // Captured input fields.
    logic [OP_W-1:0]    op_reg;
    logic [COORD_W-1:0] row_reg;
    logic [COORD_W-1:0] col_reg;
    logic               val_reg;

    // Cell store, one word per row.
    logic [MAX_COLS-1:0] mem [MAX_ROWS];
    logic [MAX_COLS-1:0] rd_data_reg;
    logic [RW-1:0]       rd_addr;
    logic [RW-1:0]       wr_addr;
    logic [MAX_COLS-1:0] wr_data;
    logic                wr_en;

    // Step state: old rows and shifting neighbor windows.
    logic [MAX_COLS-1:0] prev_reg;
    logic [MAX_COLS-1:0] cur_reg;
    logic [MAX_COLS-1:0] nxt_reg;
    logic [MAX_COLS-1:0] nxt_masked;
    logic [MAX_COLS:0]   pw_reg;
    logic [MAX_COLS:0]   cw_reg;
    logic [MAX_COLS:0]   nw_reg;
    logic [MAX_COLS-1:0] new_row_reg;
    logic [RW-1:0]       r_reg;
    logic [CW-1:0]       c_reg;
    logic [POP_W-1:0]    pop_reg;

    // Results waiting for the output register.
    logic res_alive_reg;
    logic res_err_reg;

    logic [RN-1:0]       nr;
    logic [CN-1:0]       nc;
    logic [MAX_COLS-1:0] mod_row;
    logic [CW-1:0]       col_idx;
    logic [3:0]          ncount;
    logic                right_ok;
    logic                next_cell;

    // Active size: each register clamped to the store size.
    assign nr = (32'(grid_rows_reg) < MAX_ROWS) ? RN'(grid_rows_reg) : RN'(MAX_ROWS);
    assign nc = (32'(grid_cols_reg) < MAX_COLS) ? CN'(grid_cols_reg) : CN'(MAX_COLS);

    // Status toward the controller.
    assign status.in_is_step = (op == OP_STEP);
    assign status.in_err     = (32'(cell_row) >= 32'(nr)) || (32'(cell_col) >= 32'(nc));
    assign status.row_skip   = (32'(r_reg) >= 32'(nr)) || (nc == '0);
    assign status.col_last   = (32'(c_reg) + 32'd1 == 32'(nc));
    assign status.row_last   = (32'(r_reg) == MAX_ROWS - 1);

    // Modified row for a cell access.
    assign col_idx = CW'(col_reg);
    always_comb
    begin
        mod_row = rd_data_reg;
        case (op_reg)
            OP_WRITE:  mod_row[col_idx] = val_reg;
            OP_TOGGLE: mod_row[col_idx] = ~rd_data_reg[col_idx];
            default:   ;
        endcase
    end

    // Neighbor count at the window taps; the right tap is dead past the last column.
    assign right_ok = !status.col_last;
    assign ncount = 4'(pw_reg[0]) + 4'(pw_reg[1]) + 4'(pw_reg[2] & right_ok)
                  + 4'(cw_reg[0]) + 4'(cw_reg[2] & right_ok)
                  + 4'(nw_reg[0]) + 4'(nw_reg[1]) + 4'(nw_reg[2] & right_ok);
    assign next_cell = cw_reg[1] ? ((ncount == 4'd2) || (ncount == 4'd3))
                                 : (ncount == 4'd3);

    // The row below is dead beyond the last active row.
    assign nxt_masked = (32'(r_reg) + 32'd1 < 32'(nr)) ? rd_data_reg : '0;

    // Store addresses and write data.
    always_comb
    begin
        if (cmd.accept)
        begin
            rd_addr = RW'(cell_row);
        end
        else if (cmd.step_init)
        begin
            rd_addr = '0;
        end
        else if (cmd.load0)
        begin
            rd_addr = RW'(1);
        end
        else
        begin
            rd_addr = r_reg + RW'(2);
        end
    end

    assign wr_en   = cmd.clear_row || cmd.cell_update || cmd.row_write;
    assign wr_addr = cmd.cell_update ? RW'(row_reg) : r_reg;
    assign wr_data = cmd.cell_update ? mod_row : (cmd.row_write ? new_row_reg : '0);

    // Cell store with registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= GRID_ROWS_RST;
            grid_cols_reg <= GRID_COLS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GRID_ROWS: grid_rows_reg <= cfg_data;
                REG_GRID_COLS: grid_cols_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Row counter, used by the reset clear and by the step sweep.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_reg <= '0;
        end
        else if (cmd.step_init)
        begin
            r_reg <= '0;
        end
        else if (cmd.clear_row || cmd.row_write)
        begin
            r_reg <= r_reg + RW'(1);
        end
    end

    // Input capture, line buffers, windows, population and results.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg        <= op;
            row_reg       <= cell_row;
            col_reg       <= cell_col;
            val_reg       <= cell_value;
            res_alive_reg <= 1'b0;
            res_err_reg   <= !status.in_is_step && status.in_err;
        end
        if (cmd.cell_update)
        begin
            res_alive_reg <= mod_row[col_idx];
        end
        if (cmd.step_init)
        begin
            prev_reg <= '0;
            pop_reg  <= '0;
        end
        if (cmd.load0)
        begin
            cur_reg <= rd_data_reg;
        end
        if (cmd.row_start)
        begin
            nxt_reg     <= nxt_masked;
            pw_reg      <= {prev_reg, 1'b0};
            cw_reg      <= {cur_reg, 1'b0};
            nw_reg      <= {nxt_masked, 1'b0};
            new_row_reg <= '0;
            c_reg       <= '0;
        end
        if (cmd.col_step)
        begin
            new_row_reg[c_reg] <= next_cell;
            if (next_cell && (pop_reg != POP_MAX))
            begin
                pop_reg <= pop_reg + POP_W'(1);
            end
            pw_reg <= {1'b0, pw_reg[MAX_COLS:1]};
            cw_reg <= {1'b0, cw_reg[MAX_COLS:1]};
            nw_reg <= {1'b0, nw_reg[MAX_COLS:1]};
            c_reg  <= c_reg + CW'(1);
        end
        if (cmd.row_write)
        begin
            prev_reg <= cur_reg;
            cur_reg  <= nxt_reg;
        end
        if (cmd.load_out)
        begin
            alive       <= res_alive_reg;
            coord_error <= res_err_reg;
            population  <= (op_reg == OP_STEP) ? pop_reg : '0;
        end
    end

endmodule

/* design/life_cellular_automaton_engine_core.sv */
// Top level of the Game of Life engine: controller and datapath.
//
//  Channel | Handshake         | Payload
//  --------+-------------------+------------------------------------------
//  input   | in_valid/in_stall | op, cell_row, cell_col, cell_value
//  output  | out_valid/out_stall | alive, coord_error, population
//  config  | cfg_we            | cfg_index, cfg_data
//
// A write, toggle or read goes from acceptance through the cell-update and done states
// to a valid result; a coordinate error goes straight to the done state. A step sweeps
// the store one row word at a time and the active grid one cell a cycle, a pace set by
// the single read port of the row store and the one-cell neighbor counter.
// After reset a clearing pass writes every row with input stalled.
// Input is taken only while idle; a finished result waits in the output register,
// and the next transaction is accepted while it waits.
module life_cellular_automaton_engine_core #(
    parameter int MAX_ROWS = lcae_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = lcae_pkg::DEF_MAX_COLS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [lcae_pkg::OP_W-1:0]         op,
    input  logic [lcae_pkg::COORD_W-1:0]      cell_row,
    input  logic [lcae_pkg::COORD_W-1:0]      cell_col,
    input  logic                              cell_value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              alive,
    output logic                              coord_error,
    output logic [lcae_pkg::POP_W-1:0]        population,
    input  logic                              cfg_we,
    input  logic [lcae_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lcae_pkg::CFG_W-1:0]        cfg_data
);
    import lcae_pkg::*;

    lcae_cmd_t    cmd;
    lcae_status_t status;

    // Sequencing.
    lcae_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Storage and arithmetic.
    lcae_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .cell_row    (cell_row),
        .cell_col    (cell_col),
        .cell_value  (cell_value),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .status      (status),
        .alive       (alive),
        .coord_error (coord_error),
        .population  (population)
    );

endmodule
